FILE: src/ihc_pkg.sv
// ----------------------------------------------------------------------------
// ihc_pkg: shared types and constants of the IPv4 header checker
// Transfer payloads, the record passed from parser to verdict stage,
// verdict codes and protocol numbers.
// ----------------------------------------------------------------------------
package ihc_pkg;

	// Depth of the record queue between the parser and the verdict stage.
	localparam int QUEUE_DEPTH_DEFAULT = 2;

	// Word index at which the parser waits for the next first word.
	localparam logic [4:0] IDLE_INDEX = 5'd31;
	// Fewest words read for any header, so that the fixed fields are present.
	localparam logic [5:0] MIN_WORDS = 6'd10;

	localparam logic [15:0] SUM_GOOD  = 16'hFFFF;
	localparam logic [15:0] FRAG_MASK = 16'h3FFF;
	localparam logic [3:0]  IPV4_VERSION = 4'd4;

	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SHORT    = 3'd1,
		ST_VERSION  = 3'd2,
		ST_CHECKSUM = 3'd3,
		ST_FRAGMENT = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		PC_ICMP  = 2'd0,
		PC_TCP   = 2'd1,
		PC_UDP   = 2'd2,
		PC_OTHER = 2'd3
	} proto_class_t;

	typedef struct packed {
		logic [15:0] header_word;
		logic        first_word;
		logic [15:0] frame_length;
	} word_item_t;

	typedef struct packed {
		status_t      status;
		proto_class_t proto_class;
		logic [5:0]   header_bytes;
		logic [15:0]  payload_bytes;
		logic [31:0]  src_ip;
		logic [31:0]  dst_ip;
	} verdict_item_t;

	// Everything the verdict stage needs from one parsed header.
	typedef struct packed {
		logic [15:0] received_length;
		logic [15:0] total_length;
		logic [3:0]  version;
		logic [3:0]  ihl;
		logic        sum_ok;
		logic        fragmented;
		logic [7:0]  protocol;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
	} header_rec_t;

endpackage

FILE: src/ihc_stream_if.sv
// ----------------------------------------------------------------------------
// ihc_stream_if: valid/ready stream channel
// Carries one payload per transfer; the source drives valid and data,
// the sink drives ready.
// ----------------------------------------------------------------------------
interface ihc_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: src/ipv4_header_checker.sv
// ----------------------------------------------------------------------------
// ipv4_header_checker: IPv4 header validation
// Parses an IPv4 header word by word and reports one verdict per header.
// ----------------------------------------------------------------------------
// Header words enter on the words channel one 16-bit word per transfer,
// first byte in the upper half, and first_word set on the word that opens a
// header; frame_length is sampled with that word. The block takes one word
// every cycle while the record queue has room: each word costs one 17-bit
// add with end-around carry and a field capture in the parser. After
// max(IHL*2, 10) words one verdict leaves on the verdict channel, once its
// record has passed through the record queue and then the output register. The
// status checks run in this order: short frame, wrong version, bad checksum,
// fragment. Words that arrive after a verdict and before the next first word
// are taken and dropped, and a first word in the middle of a header drops
// the partial header without a verdict. Input stalls only when the verdict
// side has held back long enough to fill the record queue and the output
// register.
// ----------------------------------------------------------------------------
module ipv4_header_checker #(
	parameter int QUEUE_DEPTH = ihc_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	ihc_stream_if.sink   words,
	ihc_stream_if.source verdict
);
	import ihc_pkg::*;

	// Record handoff from the parser into the queue.
	logic        push_valid;
	logic        push_ready;
	header_rec_t push_data;

	// Record handoff from the queue into the verdict stage.
	logic        pop_valid;
	logic        pop_ready;
	header_rec_t pop_data;

	// The parser tracks the word position and the running sum, and pushes a
	// finished record on the last word of each header.
	ihc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (words.valid),
		.in_ready   (words.ready),
		.in_data    (words.data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// The queue lets the parser keep taking words while a verdict waits.
	ihc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// The verdict stage applies the checks in priority order and holds the
	// result until the downstream transfer completes.
	ihc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (pop_valid),
		.rec_ready (pop_ready),
		.rec_data  (pop_data),
		.out_valid (verdict.valid),
		.out_ready (verdict.ready),
		.out_data  (verdict.data)
	);

endmodule

FILE: src/ihc_front.sv
// ----------------------------------------------------------------------------
// ihc_front: header word parser
// Tracks the word position, folds the ones' complement sum and captures the
// header fields; pushes one record per completed header.
// ----------------------------------------------------------------------------
module ihc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ihc_pkg::word_item_t  in_data,
	output logic                 push_valid,
	input  logic                 push_ready,
	output ihc_pkg::header_rec_t push_data
);
	import ihc_pkg::*;

	logic [4:0]  word_index_q;
	logic [16:0] sum_q;
	logic [3:0]  ihl_q;
	logic [3:0]  version_q;
	logic [15:0] total_q;
	logic [15:0] frag_q;
	logic [7:0]  proto_q;
	logic [31:0] src_q;
	logic [31:0] dst_q;
	logic [15:0] rcv_q;

	logic [4:0]  idx;
	logic        skip;
	logic        take;
	logic        last;
	logic [15:0] w;
	logic [3:0]  ihl_n;
	logic [3:0]  version_n;
	logic [15:0] rcv_n;
	logic [16:0] sum_base;
	logic [16:0] sum_raw;
	logic [16:0] sum_fold;
	logic [16:0] sum_n;
	logic [15:0] total_n;
	logic [15:0] frag_n;
	logic [7:0]  proto_n;
	logic [31:0] src_n;
	logic [31:0] dst_n;
	logic [4:0]  ihl_words;
	logic [5:0]  needed;
	logic [5:0]  idx_next;

	assign w        = in_data.header_word;
	assign in_ready = push_ready;
	assign idx      = in_data.first_word ? 5'd0 : word_index_q;
	assign skip     = !in_data.first_word && (word_index_q == IDLE_INDEX);
	assign take     = in_valid && in_ready && !skip;

	always_comb begin
		ihl_n     = (idx == 5'd0) ? w[11:8]  : ihl_q;
		version_n = (idx == 5'd0) ? w[15:12] : version_q;
		rcv_n     = (idx == 5'd0) ? in_data.frame_length : rcv_q;
		sum_base  = (idx == 5'd0) ? 17'd0 : sum_q;
		ihl_words = {ihl_n, 1'b0};

		// End-around carry: a carry out of bit 15 comes back in at bit 0.
		sum_raw  = sum_base + {1'b0, w};
		sum_fold = sum_raw[16] ? ({1'b0, sum_raw[15:0]} + 17'd1) : sum_raw;
		sum_n    = (idx < ihl_words) ? sum_fold : sum_base;

		total_n = (idx == 5'd1) ? w : total_q;
		frag_n  = (idx == 5'd3) ? w : frag_q;
		proto_n = (idx == 5'd4) ? w[7:0] : proto_q;
		src_n   = src_q;
		dst_n   = dst_q;
		if (idx == 5'd6) begin
			src_n[31:16] = w;
		end
		if (idx == 5'd7) begin
			src_n[15:0] = w;
		end
		if (idx == 5'd8) begin
			dst_n[31:16] = w;
		end
		if (idx == 5'd9) begin
			dst_n[15:0] = w;
		end

		needed   = ({1'b0, ihl_words} < MIN_WORDS) ? MIN_WORDS : {1'b0, ihl_words};
		idx_next = {1'b0, idx} + 6'd1;
		last     = !(idx_next < needed);
	end

	always_comb begin
		push_valid                = take && last;
		push_data.received_length = rcv_n;
		push_data.total_length    = total_n;
		push_data.version         = version_n;
		push_data.ihl             = ihl_n;
		push_data.sum_ok          = (sum_n[15:0] == SUM_GOOD);
		push_data.fragmented      = ((frag_n & FRAG_MASK) != 16'd0);
		push_data.protocol        = proto_n;
		push_data.src_ip          = src_n;
		push_data.dst_ip          = dst_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_index_q <= 5'd0;
			sum_q        <= 17'd0;
			ihl_q        <= 4'd0;
			version_q    <= 4'd0;
			total_q      <= 16'd0;
			frag_q       <= 16'd0;
			proto_q      <= 8'd0;
			src_q        <= 32'd0;
			dst_q        <= 32'd0;
			rcv_q        <= 16'd0;
		end else if (take) begin
			word_index_q <= last ? IDLE_INDEX : idx_next[4:0];
			sum_q        <= sum_n;
			ihl_q        <= ihl_n;
			version_q    <= version_n;
			total_q      <= total_n;
			frag_q       <= frag_n;
			proto_q      <= proto_n;
			src_q        <= src_n;
			dst_q        <= dst_n;
			rcv_q        <= rcv_n;
		end
	end

endmodule

FILE: src/ihc_queue.sv
// ----------------------------------------------------------------------------
// ihc_queue: header record queue
// Small first-in first-out store between the parser and the verdict stage.
// ----------------------------------------------------------------------------
module ihc_queue #(
	parameter int DEPTH = ihc_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  ihc_pkg::header_rec_t push_data,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output ihc_pkg::header_rec_t pop_data
);
	import ihc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	header_rec_t   mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: src/ihc_back.sv
// ----------------------------------------------------------------------------
// ihc_back: verdict stage
// Turns a header record into the verdict, protocol class and byte counts,
// held in an output register until the transfer completes.
// ----------------------------------------------------------------------------
module ihc_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   rec_valid,
	output logic                   rec_ready,
	input  ihc_pkg::header_rec_t   rec_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output ihc_pkg::verdict_item_t out_data
);
	import ihc_pkg::*;

	logic          valid_q;
	verdict_item_t data_q;
	verdict_item_t next_item;
	logic [15:0]   hbytes_wide;
	logic          load;

	assign rec_ready = !valid_q || out_ready;
	assign load      = rec_valid && rec_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_comb begin
		hbytes_wide = {10'd0, rec_data.ihl, 2'b00};

		priority if (rec_data.received_length < rec_data.total_length) begin
			next_item.status = ST_SHORT;
		end else if (rec_data.version != IPV4_VERSION) begin
			next_item.status = ST_VERSION;
		end else if (!rec_data.sum_ok) begin
			next_item.status = ST_CHECKSUM;
		end else if (rec_data.fragmented) begin
			next_item.status = ST_FRAGMENT;
		end else begin
			next_item.status = ST_OK;
		end

		unique case (rec_data.protocol)
			PROTO_ICMP: next_item.proto_class = PC_ICMP;
			PROTO_TCP:  next_item.proto_class = PC_TCP;
			PROTO_UDP:  next_item.proto_class = PC_UDP;
			default:    next_item.proto_class = PC_OTHER;
		endcase

		next_item.header_bytes  = {rec_data.ihl, 2'b00};
		next_item.payload_bytes = (rec_data.total_length > hbytes_wide) ?
			(rec_data.total_length - hbytes_wide) : 16'd0;
		next_item.src_ip        = rec_data.src_ip;
		next_item.dst_ip        = rec_data.dst_ip;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= next_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

FILE: verif/ipv4_header_checker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_header_checker_tb: self-checking bench for the IPv4 header checker
// Builds IPv4 headers word by word, sends them over the words channel with
// random gaps, and checks every verdict against a predictor kept in the bench.
// ----------------------------------------------------------------------------
module ipv4_header_checker_tb;
	import ihc_pkg::*;

	// Word offsets of the fixed fields inside an IPv4 header.
	localparam int W_VER_IHL   = 0;
	localparam int W_TOTAL_LEN = 1;
	localparam int W_FRAG      = 3;
	localparam int W_TTL_PROTO = 4;
	localparam int W_CHECKSUM  = 5;
	localparam int W_SRC_HI    = 6;
	localparam int W_SRC_LO    = 7;
	localparam int W_DST_HI    = 8;
	localparam int W_DST_LO    = 9;

	// Fragment field values used by the directed headers.
	localparam logic [15:0] FLAG_DF         = 16'h4000;
	localparam logic [15:0] FLAG_MF         = 16'h2000;
	localparam logic [15:0] OFFSET_ALL_ONES = 16'h1FFF;

	// Header words that must be parsed before the stimulus stops.
	localparam int WORD_TARGET = 1550;
	// Cycles allowed after the last verdict for stray transfers to show up.
	localparam int SETTLE_CYCLES = 10;
	// Hard stop, far above the slowest legal run.
	localparam longint TIMEOUT_NS = 64'd20_000_000;

	logic clk;
	logic arst_n;

	ihc_stream_if #(.data_t(word_item_t))    words_if ();
	ihc_stream_if #(.data_t(verdict_item_t)) verdict_if ();

	ipv4_header_checker dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.words   (words_if),
		.verdict (verdict_if)
	);

	// Parser state of the predictor; all of it is zero out of reset.
	logic [4:0]  parse_pos     = '0;
	logic [16:0] csum_acc      = '0;
	logic [3:0]  hdr_ihl       = '0;
	logic [3:0]  hdr_version   = '0;
	logic [15:0] hdr_total_len = '0;
	logic [15:0] hdr_frag      = '0;
	logic [7:0]  hdr_protocol  = '0;
	logic [31:0] hdr_src       = '0;
	logic [31:0] hdr_dst       = '0;
	logic [15:0] hdr_frame_len = '0;

	verdict_item_t expected_verdicts[$];
	logic [15:0]   hdr_words[$];

	int unsigned fail_count       = 0;
	int unsigned words_parsed     = 0;
	int unsigned verdicts_checked = 0;
	int unsigned status_seen[5]   = '{default: 0};

	// Traffic shaping knobs, changed from phase to phase.
	bit          gaps_on   = 1'b0;
	int unsigned stall_pct = 0;
	int unsigned stall_left = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("FAILED: results differ");
		$finish;
	end

	// Mostly no pause, often a short one, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Ones' complement addition with the carry wrapped back into bit 0.
	function automatic logic [16:0] ones_add(input logic [16:0] acc, input logic [15:0] w);
		logic [16:0] s;
		s = acc + {1'b0, w};
		if (s > 17'h0FFFF) begin
			s = {1'b0, s[15:0]} + 17'd1;
		end
		return s;
	endfunction

	// Advances the predicted parser by one accepted word and queues the verdict
	// when the word closes a header.
	function automatic void predict_word(input word_item_t it);
		logic [4:0]    pos;
		logic [5:0]    needed;
		logic [5:0]    hbytes;
		status_t       st;
		proto_class_t  pc;
		verdict_item_t v;
		if (it.first_word) begin
			pos = '0;
		end else if (parse_pos == IDLE_INDEX) begin
			// Nothing open: the word is dropped.
			return;
		end else begin
			pos = parse_pos;
		end
		words_parsed++;
		if (pos == 5'(W_VER_IHL)) begin
			csum_acc      = '0;
			hdr_version   = it.header_word[15:12];
			hdr_ihl       = it.header_word[11:8];
			hdr_frame_len = it.frame_length;
		end
		// Only the words that belong to the header proper enter the sum.
		if ({1'b0, pos} < {1'b0, hdr_ihl, 1'b0}) begin
			csum_acc = ones_add(csum_acc, it.header_word);
		end
		case (pos)
			5'(W_TOTAL_LEN): begin
				hdr_total_len = it.header_word;
			end
			5'(W_FRAG): begin
				hdr_frag = it.header_word;
			end
			5'(W_TTL_PROTO): begin
				hdr_protocol = it.header_word[7:0];
			end
			5'(W_SRC_HI): begin
				hdr_src[31:16] = it.header_word;
			end
			5'(W_SRC_LO): begin
				hdr_src[15:0] = it.header_word;
			end
			5'(W_DST_HI): begin
				hdr_dst[31:16] = it.header_word;
			end
			5'(W_DST_LO): begin
				hdr_dst[15:0] = it.header_word;
			end
			default: begin
			end
		endcase
		needed = {1'b0, hdr_ihl, 1'b0};
		if (needed < MIN_WORDS) begin
			needed = MIN_WORDS;
		end
		if ({1'b0, pos} + 6'd1 < needed) begin
			parse_pos = pos + 5'd1;
			return;
		end
		parse_pos = IDLE_INDEX;
		hbytes = {hdr_ihl, 2'b00};
		if (hdr_frame_len < hdr_total_len) begin
			st = ST_SHORT;
		end else if (hdr_version != IPV4_VERSION) begin
			st = ST_VERSION;
		end else if (csum_acc[15:0] != SUM_GOOD) begin
			st = ST_CHECKSUM;
		end else if ((hdr_frag & FRAG_MASK) != '0) begin
			st = ST_FRAGMENT;
		end else begin
			st = ST_OK;
		end
		if (hdr_protocol == PROTO_ICMP) begin
			pc = PC_ICMP;
		end else if (hdr_protocol == PROTO_TCP) begin
			pc = PC_TCP;
		end else if (hdr_protocol == PROTO_UDP) begin
			pc = PC_UDP;
		end else begin
			pc = PC_OTHER;
		end
		v.status        = st;
		v.proto_class   = pc;
		v.header_bytes  = hbytes;
		v.payload_bytes = (hdr_total_len > 16'(hbytes)) ? hdr_total_len - 16'(hbytes) : '0;
		v.src_ip        = hdr_src;
		v.dst_ip        = hdr_dst;
		expected_verdicts.push_back(v);
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	function automatic void check_verdict(input verdict_item_t got);
		verdict_item_t want;
		if (expected_verdicts.size() == 0) begin
			$error("verdict with nothing expected: status %0d, src 0x%0h", got.status,
				got.src_ip);
			fail_count++;
			return;
		end
		want = expected_verdicts.pop_front();
		verdicts_checked++;
		if (want.status <= ST_FRAGMENT) begin
			status_seen[want.status]++;
		end
		compare_field("status", 32'(want.status), 32'(got.status));
		compare_field("proto_class", 32'(want.proto_class), 32'(got.proto_class));
		compare_field("header_bytes", 32'(want.header_bytes), 32'(got.header_bytes));
		compare_field("payload_bytes", 32'(want.payload_bytes), 32'(got.payload_bytes));
		compare_field("src_ip", want.src_ip, got.src_ip);
		compare_field("dst_ip", want.dst_ip, got.dst_ip);
	endfunction

	// Both channels are sampled at the rising edge, where the inputs driven at
	// the falling edge are settled and the block's outputs still hold their
	// values from the previous cycle.
	always @(posedge clk) begin
		if (arst_n && words_if.valid && words_if.ready) begin
			predict_word(words_if.data);
		end
		if (arst_n && verdict_if.valid && verdict_if.ready) begin
			check_verdict(verdict_if.data);
		end
	end

	// Verdict side: ready drops for a random stretch with the chance that the
	// current phase asks for, and stays high otherwise.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			verdict_if.ready <= 1'b0;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			stall_left = pick_gap();
			verdict_if.ready <= 1'b0;
		end else begin
			verdict_if.ready <= 1'b1;
		end
	end

	// Offers one word and returns at the falling edge after its transfer. Each
	// call is entered at a falling edge where valid has not yet been driven.
	task automatic send_word(input logic [15:0] w, input logic first, input logic [15:0] flen);
		int unsigned gap;
		gap = gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			words_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		words_if.data  <= '{header_word: w, first_word: first, frame_length: flen};
		words_if.valid <= 1'b1;
		do @(posedge clk); while (!words_if.ready);
		@(negedge clk);
	endtask

	// Fills hdr_words with a header of the given fields. The checksum word is
	// set so that the summed words fold to all ones, or one bit off when a bad
	// checksum is wanted. Options, ToS, id and TTL are random.
	function automatic void build_header(input logic [3:0] ver, input logic [3:0] ihl,
			input logic [15:0] total, input logic [15:0] frag, input logic [7:0] proto,
			input logic [31:0] src, input logic [31:0] dst, input bit good_sum);
		int unsigned count;
		logic [16:0] acc;
		count = (int'(ihl) * 2 < 10) ? 10 : int'(ihl) * 2;
		hdr_words.delete();
		for (int i = 0; i < count; i++) begin
			hdr_words.push_back(16'($urandom));
		end
		hdr_words[W_VER_IHL]   = {ver, ihl, hdr_words[W_VER_IHL][7:0]};
		hdr_words[W_TOTAL_LEN] = total;
		hdr_words[W_FRAG]      = frag;
		hdr_words[W_TTL_PROTO] = {hdr_words[W_TTL_PROTO][15:8], proto};
		hdr_words[W_CHECKSUM]  = '0;
		hdr_words[W_SRC_HI]    = src[31:16];
		hdr_words[W_SRC_LO]    = src[15:0];
		hdr_words[W_DST_HI]    = dst[31:16];
		hdr_words[W_DST_LO]    = dst[15:0];
		acc = '0;
		for (int i = 0; i < int'(ihl) * 2; i++) begin
			acc = ones_add(acc, hdr_words[i]);
		end
		hdr_words[W_CHECKSUM] = ~acc[15:0];
		if (!good_sum) begin
			hdr_words[W_CHECKSUM] ^= 16'(1 << $urandom_range(0, 15));
		end
	endfunction

	// Sends the first count words of hdr_words. frame_length only matters on
	// the opening word, so the other words carry random values there.
	task automatic send_header(input logic [15:0] frame_len, input bit mark_first,
			input int unsigned count);
		for (int i = 0; i < count; i++) begin
			send_word(hdr_words[i], (i == 0) && mark_first,
				(i == 0) ? frame_len : 16'($urandom));
		end
	endtask

	task automatic send_full(input logic [3:0] ver, input logic [3:0] ihl,
			input logic [15:0] total, input logic [15:0] frag, input logic [7:0] proto,
			input logic [31:0] src, input logic [31:0] dst, input bit good_sum,
			input logic [15:0] frame_len);
		build_header(ver, ihl, total, frag, proto, src, dst, good_sum);
		send_header(frame_len, 1'b1, hdr_words.size());
	endtask

	// Holds the words channel idle until every expected verdict has arrived.
	task automatic wait_for_verdicts();
		words_if.valid <= 1'b0;
		@(negedge clk);
		while (expected_verdicts.size() != 0) @(negedge clk);
	endtask

	// Straight out of reset the parser already sits at word 0, so a header whose
	// opening word lacks the first-word mark is still parsed in full.
	task automatic test_reset_without_first_word();
		build_header(IPV4_VERSION, 4'd5, 16'd60, '0, PROTO_TCP, 32'hC0A8_0001,
			32'h0A00_0001, 1'b1);
		send_header(16'd60, 1'b0, hdr_words.size());
	endtask

	// After a verdict, words without the first-word mark must be dropped, even
	// ones that look like a header start.
	task automatic test_ignored_words();
		send_word(16'hFFFF, 1'b0, 16'hFFFF);
		send_word(16'h0000, 1'b0, 16'h0000);
		send_word(16'h4500, 1'b0, 16'h0040);
	endtask

	// At least one header per verdict code, among them the DF flag alone, which is not a
	// fragment, and a header that fails every check so that priority shows.
	task automatic test_verdict_codes();
		send_full(IPV4_VERSION, 4'd5, 16'd40, FLAG_DF, PROTO_TCP, 32'h0102_0304,
			32'h0506_0708, 1'b1, 16'd40);
		send_full(IPV4_VERSION, 4'd5, 16'd100, '0, PROTO_UDP, 32'h0A0B_0C0D,
			32'h1112_1314, 1'b1, 16'd99);
		send_full(4'd6, 4'd5, 16'd28, '0, PROTO_ICMP, 32'h7F00_0001, 32'h7F00_0002,
			1'b1, 16'd28);
		send_full(4'd15, 4'd5, 16'd28, '0, PROTO_ICMP, 32'h8000_0000, 32'h0000_0001,
			1'b1, 16'd500);
		send_full(IPV4_VERSION, 4'd5, 16'd1500, '0, PROTO_TCP, 32'hAC10_0001,
			32'hAC10_00FE, 1'b0, 16'd1500);
		send_full(IPV4_VERSION, 4'd5, 16'd576, FLAG_MF, PROTO_UDP, 32'h0A00_0001,
			32'h0A00_0002, 1'b1, 16'd600);
		send_full(IPV4_VERSION, 4'd5, 16'd576, OFFSET_ALL_ONES, PROTO_TCP, 32'h0A00_0003,
			32'h0A00_0004, 1'b1, 16'd576);
		send_full(4'd0, 4'd5, 16'hFFFF, 16'hFFFF, PROTO_TCP, 32'h1234_5678,
			32'h9ABC_DEF0, 1'b0, 16'hFFFE);
	endtask

	task automatic test_protocol_classes();
		send_full(IPV4_VERSION, 4'd5, 16'd84, '0, PROTO_ICMP, 32'hC633_6401,
			32'hC633_6402, 1'b1, 16'd84);
		send_full(IPV4_VERSION, 4'd5, 16'd84, '0, 8'd0, 32'hC633_6403, 32'hC633_6404,
			1'b1, 16'd84);
		send_full(IPV4_VERSION, 4'd5, 16'd84, '0, 8'hFF, 32'hC633_6405, 32'hC633_6406,
			1'b1, 16'd84);
	endtask

	// The longest header with all-ones fields, headers shorter than the fixed
	// part (ten words are still read, fewer are summed; with IHL zero nothing is
	// summed at all), and a total length below the header size, which must
	// clamp the payload count at zero.
	task automatic test_header_lengths();
		send_full(IPV4_VERSION, 4'd15, 16'hFFFF, '0, PROTO_UDP, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 1'b1, 16'hFFFF);
		send_full(IPV4_VERSION, 4'd0, 16'd20, '0, PROTO_TCP, 32'h0000_0000,
			32'h0000_0000, 1'b1, 16'd20);
		send_full(IPV4_VERSION, 4'd2, 16'd8, '0, PROTO_ICMP, 32'hFFFF_0000,
			32'h0000_FFFF, 1'b1, 16'd8);
		send_full(IPV4_VERSION, 4'd4, 16'd0, '0, PROTO_UDP, 32'h5555_AAAA,
			32'hAAAA_5555, 1'b1, 16'd0);
		send_full(IPV4_VERSION, 4'd5, 16'd8, '0, PROTO_TCP, 32'h0000_0000,
			32'h0000_0000, 1'b1, 16'd8);
	endtask

	// A new first word in the middle of a header throws the partial one away;
	// the second header is cut one word short of its verdict.
	task automatic test_restart();
		build_header(IPV4_VERSION, 4'd5, 16'd60, '0, PROTO_TCP, 32'h0101_0101,
			32'h0202_0202, 1'b1);
		send_header(16'd60, 1'b1, 4);
		build_header(IPV4_VERSION, 4'd15, 16'd200, '0, PROTO_UDP, 32'h0303_0303,
			32'h0404_0404, 1'b1);
		send_header(16'd200, 1'b1, hdr_words.size() - 1);
		send_full(IPV4_VERSION, 4'd5, 16'd60, '0, PROTO_ICMP, 32'h0505_0505,
			32'h0606_0606, 1'b1, 16'd60);
	endtask

	// One random header. Most are well formed so that the verdict priority is
	// reached with every kind of field content; some carry one or more faults,
	// some are cut off by the next header, and some are followed by stray words.
	task automatic send_random_header();
		int unsigned r;
		int unsigned ihl;
		logic [3:0]  ver;
		logic [7:0]  proto;
		logic [15:0] frag;
		logic [15:0] total;
		logic [15:0] frame_len;
		bit          good_sum;
		r = $urandom_range(0, 99);
		ihl = (r < 70) ? 5 : (r < 90) ? $urandom_range(6, 15) : $urandom_range(0, 4);
		ver = ($urandom_range(0, 9) != 0) ? IPV4_VERSION : 4'($urandom);
		case ($urandom_range(0, 3))
			0: proto = PROTO_ICMP;
			1: proto = PROTO_TCP;
			2: proto = PROTO_UDP;
			default: proto = 8'($urandom);
		endcase
		r = $urandom_range(0, 99);
		frag = (r < 70) ? 16'h0000 : (r < 85) ? FLAG_DF : 16'($urandom);
		total = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(ihl * 4, 1500))
			: 16'($urandom);
		if ($urandom_range(0, 99) < 85 || total == 0) begin
			frame_len = 16'($urandom_range(int'(total), 65535));
		end else begin
			frame_len = 16'($urandom_range(0, int'(total) - 1));
		end
		good_sum = ($urandom_range(0, 9) != 0);
		build_header(ver, 4'(ihl), total, frag, proto, $urandom, $urandom, good_sum);
		if ($urandom_range(0, 99) < 8) begin
			send_header(frame_len, 1'b1, $urandom_range(1, hdr_words.size() - 1));
		end else begin
			send_header(frame_len, 1'b1, hdr_words.size());
		end
		if ($urandom_range(0, 99) < 8) begin
			repeat ($urandom_range(1, 4)) begin
				send_word(16'($urandom), 1'b0, 16'($urandom));
			end
		end
	endtask

	// Random traffic in phases of about 150 words. Each phase picks its own
	// sender gaps and receiver stalls, and some phases begin by letting every
	// outstanding verdict drain before the sender resumes.
	task automatic test_random_headers();
		int unsigned phase_end;
		phase_end = 0;
		while (words_parsed < WORD_TARGET) begin
			if (words_parsed >= phase_end) begin
				gaps_on = ($urandom_range(0, 3) != 0);
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 10;
					2: stall_pct = 40;
					default: stall_pct = 85;
				endcase
				if ($urandom_range(0, 2) == 0) begin
					wait_for_verdicts();
				end
				phase_end = words_parsed + 150;
			end
			send_random_header();
		end
	endtask

	initial begin
		words_if.valid   = 1'b0;
		words_if.data    = '0;
		verdict_if.ready = 1'b0;
		arst_n           = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The first headers go through with no idling on either side.
		test_reset_without_first_word();
		test_ignored_words();
		gaps_on   = 1'b1;
		stall_pct = 30;
		test_verdict_codes();
		test_protocol_classes();
		stall_pct = 85;
		test_header_lengths();
		test_restart();
		// The sender holds off here until every verdict so far has arrived.
		wait_for_verdicts();
		test_random_headers();

		wait_for_verdicts();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Run covered %0d parsed header words and %0d checked verdicts.",
			words_parsed, verdicts_checked);
		$display("Verdicts by status: ok %0d, short %0d, version %0d, checksum %0d, fragment %0d.",
			status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_VERSION],
			status_seen[ST_CHECKSUM], status_seen[ST_FRAGMENT]);
		if (fail_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
